/* rtl/core/safl_pkg.sv */
// package for the slot ack floor tracker
// shared types, request and outcome codes, default slot count; no dependencies
package safl_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam logic [15:0] STALL_LIMIT = 16'd3;

    // request types
    localparam logic [1:0] REQ_ACK      = 2'd0;
    localparam logic [1:0] REQ_ACTIVATE = 2'd1;
    localparam logic [1:0] REQ_RELEASE  = 2'd2;
    localparam logic [1:0] REQ_EMPTY    = 2'd3;

    // outcome codes
    localparam logic [3:0] OUT_SKIPPED        = 4'd0;
    localparam logic [3:0] OUT_MERGED         = 4'd1;
    localparam logic [3:0] OUT_ADVANCED       = 4'd2;
    localparam logic [3:0] OUT_STALE          = 4'd3;
    localparam logic [3:0] OUT_EPOCH_MISMATCH = 4'd4;
    localparam logic [3:0] OUT_ACTIVATED      = 4'd5;
    localparam logic [3:0] OUT_RELEASED       = 4'd6;
    localparam logic [3:0] OUT_REL_REFUSED    = 4'd7;
    localparam logic [3:0] OUT_EMPTY          = 4'd8;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         slot_index;
        logic [15:0]        epoch;
        logic signed [63:0] ack_floor;
        logic [63:0]        recv_bits_low;
        logic [63:0]        recv_bits_high;
        logic signed [63:0] latest_sent_tick;
        logic               last_of_message;
        logic signed [63:0] client_time_ns;
    } t_safl_in;

    typedef struct packed {
        logic [3:0]         outcome;
        logic [7:0]         echo_slot;
        logic signed [63:0] slot_floor_now;
        logic               floor_stalled;
        logic [15:0]        stall_run;
        logic [15:0]        peak_stall_run;
        logic signed [63:0] newest_client_time;
    } t_safl_out;

    // one row of the slot table
    typedef struct packed {
        logic        active;
        logic [15:0] epoch;
        logic [63:0] floor;
        logic [63:0] bits_low;
        logic [63:0] bits_high;
    } t_slot_entry;

    // per-client message tracking state
    typedef struct packed {
        logic        adv;
        logic [15:0] run;
        logic [15:0] peak;
        logic        stalled;
        logic [63:0] tmax;
    } t_glob_state;

endpackage

/* rtl/core/slot_ack_floor_tracker_unit.sv */
// slot ack floor tracker: top level with read stage, update stage and result register
// each accepted transaction: table read, then update, then result register
// one transaction per cycle unless the output stalls; the table row read and
// write-back overlap, a write to the row read at the same edge is forwarded
// inside the slot memory; reset clears control and message state, table rows read
// as zero until first written (valid bit per row), so no clearing pass is needed
module slot_ack_floor_tracker_unit #(
    parameter int SLOT_COUNT = safl_pkg::SLOT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  safl_pkg::t_safl_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output safl_pkg::t_safl_out o_out_data
);
    import safl_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic         in_accept;
    logic         out_take;
    logic         s1_move;
    logic         in_ok;
    logic         r_s1_vld;
    t_safl_in     r_s1_req;
    logic         r_s1_ok;
    t_slot_entry  rd_entry;
    t_slot_entry  upd_entry;
    logic         upd_wr_en;
    logic [3:0]   upd_outcome;
    t_glob_state  upd_glob;
    t_glob_state  r_glob;
    logic         r_out_vld;
    t_safl_out    r_out_data;

    assign in_ok     = i_in_data.slot_index < 8'(SLOT_COUNT);
    assign out_take  = r_out_vld && !i_out_stall;
    assign s1_move   = r_s1_vld && (!r_out_vld || out_take);
    assign o_in_stall = r_s1_vld && !s1_move;
    assign in_accept = i_in_valid && !o_in_stall;

    safl_slot_mem #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (in_accept && in_ok),
        .i_rd_idx (i_in_data.slot_index[IDX_W-1:0]),
        .i_wr_en  (s1_move && upd_wr_en),
        .i_wr_idx (r_s1_req.slot_index[IDX_W-1:0]),
        .i_wr_data(upd_entry),
        .o_rd_data(rd_entry)
    );

    safl_update u_update (
        .i_req    (r_s1_req),
        .i_ok     (r_s1_ok),
        .i_entry  (rd_entry),
        .i_glob   (r_glob),
        .o_entry  (upd_entry),
        .o_wr_en  (upd_wr_en),
        .o_outcome(upd_outcome),
        .o_glob   (upd_glob)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_glob    <= '0;
        end else begin
            if (in_accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
                r_glob    <= upd_glob;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_req <= i_in_data;
            r_s1_ok  <= in_ok;
        end
        if (s1_move) begin
            r_out_data.outcome            <= upd_outcome;
            r_out_data.echo_slot          <= r_s1_req.slot_index;
            r_out_data.slot_floor_now     <= r_s1_ok ? upd_entry.floor : '0;
            r_out_data.floor_stalled      <= upd_glob.stalled;
            r_out_data.stall_run          <= upd_glob.run;
            r_out_data.peak_stall_run     <= upd_glob.peak;
            r_out_data.newest_client_time <= upd_glob.tmax;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // input side only waits when a finished result is still held
    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_vld && r_out_vld && i_out_stall))
        else $error("input stalled without a held result");

    a_move_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_vld)
        else $error("update stage moved but no result registered");

    a_stalled_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_glob.stalled |-> (r_glob.peak >= STALL_LIMIT))
        else $error("stalled flag set with peak run below limit");

    a_run_clear_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_req.req_type == REQ_ACK && r_s1_req.last_of_message
         && upd_outcome == OUT_ADVANCED) |=> (r_glob.run == '0 && !r_glob.adv))
        else $error("advancing message did not clear the run");

endmodule

/* rtl/core/safl_slot_mem.sv */
// slot table memory: one write port, one registered read port
// valid bit per row stands in for the zero reset; depends on safl_pkg
module safl_slot_mem #(
    parameter int SLOT_COUNT = safl_pkg::SLOT_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] i_rd_idx,
    input  logic                 i_wr_en,
    input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] i_wr_idx,
    input  safl_pkg::t_slot_entry i_wr_data,
    output safl_pkg::t_slot_entry o_rd_data
);
    import safl_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    t_slot_entry            r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  r_valid;
    t_slot_entry            r_q;
    logic                   r_q_vld;
    logic                   r_fwd;
    t_slot_entry            r_fwd_data;
    logic                   rd_in_range;
    logic                   wr_in_range;

    assign rd_in_range = {1'b0, i_rd_idx} < (IDX_W + 1)'(SLOT_COUNT);
    assign wr_in_range = {1'b0, i_wr_idx} < (IDX_W + 1)'(SLOT_COUNT);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_in_range) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en && wr_in_range) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    // a write landing on the row being read at the same edge is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en && rd_in_range) begin
            r_q        <= r_mem[i_rd_idx];
            r_q_vld    <= r_valid[i_rd_idx];
            r_fwd      <= i_wr_en && (i_wr_idx == i_rd_idx);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : (r_q_vld ? r_q : '0);

endmodule

/* rtl/core/safl_update.sv */
// read-modify-write logic for one request: new slot row, outcome, message state
// purely combinational; depends on safl_pkg
module safl_update (
    input  safl_pkg::t_safl_in    i_req,
    input  logic                  i_ok,
    input  safl_pkg::t_slot_entry i_entry,
    input  safl_pkg::t_glob_state i_glob,
    output safl_pkg::t_slot_entry o_entry,
    output logic                  o_wr_en,
    output logic [3:0]            o_outcome,
    output safl_pkg::t_glob_state o_glob
);
    import safl_pkg::*;

    logic [63:0] clamp;
    logic        apply_time;

    assign clamp = ($signed(i_req.latest_sent_tick) < $signed(i_req.ack_floor))
                   ? i_req.latest_sent_tick : i_req.ack_floor;

    always_comb begin
        o_entry    = i_entry;
        o_glob     = i_glob;
        o_wr_en    = 1'b0;
        o_outcome  = OUT_SKIPPED;
        apply_time = 1'b0;
        case (i_req.req_type)
            REQ_ACK: begin
                if (i_ok && i_entry.active) begin
                    if (i_req.epoch != i_entry.epoch) begin
                        o_outcome = OUT_EPOCH_MISMATCH;
                    end else if ($signed(i_req.ack_floor) < $signed(i_entry.floor)) begin
                        o_outcome = OUT_STALE;
                    end else if (clamp == i_entry.floor) begin
                        o_entry.bits_low  = i_entry.bits_low | i_req.recv_bits_low;
                        o_entry.bits_high = i_entry.bits_high | i_req.recv_bits_high;
                        o_wr_en   = 1'b1;
                        o_outcome = OUT_MERGED;
                    end else begin
                        // clamp may land below the stored floor, still an advance
                        o_entry.floor     = clamp;
                        o_entry.bits_low  = i_req.recv_bits_low;
                        o_entry.bits_high = i_req.recv_bits_high;
                        o_glob.adv = 1'b1;
                        o_wr_en    = 1'b1;
                        o_outcome  = OUT_ADVANCED;
                    end
                end
                if (i_req.last_of_message) begin
                    if (o_glob.adv) begin
                        if (o_glob.stalled) begin
                            o_glob.stalled = 1'b0;
                            o_glob.peak    = '0;
                        end
                        o_glob.run = '0;
                    end else begin
                        if (o_glob.run != '1) begin
                            o_glob.run = o_glob.run + 16'd1;
                        end
                        if (o_glob.run > o_glob.peak) begin
                            o_glob.peak = o_glob.run;
                        end
                        if (o_glob.run >= STALL_LIMIT) begin
                            o_glob.stalled = 1'b1;
                        end
                    end
                    o_glob.adv = 1'b0;
                    apply_time = 1'b1;
                end
            end
            REQ_ACTIVATE: begin
                if (i_ok && !i_entry.active) begin
                    o_entry.active    = 1'b1;
                    o_entry.epoch     = i_entry.epoch + 16'd1;
                    o_entry.floor     = '0;
                    o_entry.bits_low  = '0;
                    o_entry.bits_high = '0;
                    o_wr_en   = 1'b1;
                    o_outcome = OUT_ACTIVATED;
                end
            end
            REQ_RELEASE: begin
                if (i_ok && i_entry.active && (i_entry.epoch == i_req.epoch)) begin
                    o_entry.active = 1'b0;
                    o_wr_en   = 1'b1;
                    o_outcome = OUT_RELEASED;
                end else begin
                    o_outcome = OUT_REL_REFUSED;
                end
            end
            default: begin
                apply_time = 1'b1;
                o_outcome  = OUT_EMPTY;
            end
        endcase
        if (apply_time && ($signed(i_req.client_time_ns) > $signed(o_glob.tmax))) begin
            o_glob.tmax = i_req.client_time_ns;
        end
    end

endmodule

/* bench/tb.sv */
// testbench for slot_ack_floor_tracker_unit: directed table, random mixed requests, full-rate tail
// depends on safl_pkg and the tracker rtl; checks every result against the directed table or a local predictor
module tb;
    import safl_pkg::*;

    localparam int NSLOT        = SLOT_COUNT_DEF;
    localparam int CYC_LIMIT    = 2000000;
    localparam int RND_ITEMS    = 420;
    localparam int SOAK_ROUNDS  = 20;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int SOAK_SLOT    = 5;
    localparam int DIR_MAX      = 32;
    localparam int EXP_DEPTH    = 8;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [63:0]        ONES64  = {64{1'b1}};

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_safl_in  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_safl_out o_out_data;

    slot_ack_floor_tracker_unit #(
        .SLOT_COUNT(NSLOT)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // predictor copy of the slot table and message state
    logic               slot_on [NSLOT];
    logic [15:0]        slot_ep [NSLOT];
    logic signed [63:0] slot_fl [NSLOT];
    logic [63:0]        slot_lo [NSLOT];
    logic [63:0]        slot_hi [NSLOT];
    logic               msg_advanced = 1'b0;
    logic [15:0]        run_len      = '0;
    logic [15:0]        run_peak     = '0;
    logic               stalled_now  = 1'b0;
    logic signed [63:0] t_max        = '0;

    // expected results in flight, written at input accept, read at output accept
    t_safl_out exp_ring [EXP_DEPTH];
    int        exp_wr = 0;
    int        exp_rd = 0;
    t_safl_in  dir_stim [DIR_MAX];
    bit        dir_typed [DIR_MAX];
    t_safl_out dir_want [DIR_MAX];
    int        dir_n = 0;
    t_safl_out blank = '0;

    logic idle_on   = 1'b1;
    logic long_hold = 1'b0;
    int   cyc_cnt   = 0;
    int   bad_cnt   = 0;
    int   acc_cnt   = 0;
    int   rnd_cnt   = 0;
    int   msg_left  = 0;
    int   tx_calm   = 0;
    int   rx_left   = 0;
    int   hist[0:8];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < NSLOT; k++) begin
            slot_on[k] = 1'b0;
            slot_ep[k] = '0;
            slot_fl[k] = '0;
            slot_lo[k] = '0;
            slot_hi[k] = '0;
        end
        for (int k = 0; k <= 8; k++) hist[k] = 0;
    end

    function automatic void note_time(input logic signed [63:0] t);
        if (t > t_max) t_max = t;
    endfunction

    function automatic t_safl_out track_floor_step(input t_safl_in it);
        t_safl_out          r;
        int unsigned        s;
        logic               in_rng;
        logic signed [63:0] clamped;
        s = it.slot_index;
        in_rng = (s < NSLOT);
        r = '0;
        r.outcome = OUT_SKIPPED;
        case (it.req_type)
            REQ_ACK: begin
                if (in_rng && slot_on[s]) begin
                    if (it.epoch != slot_ep[s]) begin
                        r.outcome = OUT_EPOCH_MISMATCH;
                    end else if ($signed(it.ack_floor) < slot_fl[s]) begin
                        r.outcome = OUT_STALE;
                    end else begin
                        clamped = ($signed(it.latest_sent_tick) < $signed(it.ack_floor)) ?
                                  it.latest_sent_tick : it.ack_floor;
                        if (clamped == slot_fl[s]) begin
                            slot_lo[s] = slot_lo[s] | it.recv_bits_low;
                            slot_hi[s] = slot_hi[s] | it.recv_bits_high;
                            r.outcome = OUT_MERGED;
                        end else begin
                            // clamp may land below the stored floor, still an advance
                            slot_fl[s] = clamped;
                            slot_lo[s] = it.recv_bits_low;
                            slot_hi[s] = it.recv_bits_high;
                            msg_advanced = 1'b1;
                            r.outcome = OUT_ADVANCED;
                        end
                    end
                end
                if (it.last_of_message) begin
                    if (msg_advanced) begin
                        if (stalled_now) begin
                            stalled_now = 1'b0;
                            run_peak = '0;
                        end
                        run_len = '0;
                    end else begin
                        if (run_len != 16'hFFFF) run_len = run_len + 16'd1;
                        if (run_len > run_peak) run_peak = run_len;
                        if (run_len >= STALL_LIMIT) stalled_now = 1'b1;
                    end
                    msg_advanced = 1'b0;
                    note_time(it.client_time_ns);
                end
            end
            REQ_ACTIVATE: begin
                if (in_rng && !slot_on[s]) begin
                    slot_on[s] = 1'b1;
                    slot_ep[s] = slot_ep[s] + 16'd1;
                    slot_fl[s] = '0;
                    slot_lo[s] = '0;
                    slot_hi[s] = '0;
                    r.outcome = OUT_ACTIVATED;
                end
            end
            REQ_RELEASE: begin
                if (in_rng && slot_on[s] && slot_ep[s] == it.epoch) begin
                    slot_on[s] = 1'b0;
                    r.outcome = OUT_RELEASED;
                end else begin
                    r.outcome = OUT_REL_REFUSED;
                end
            end
            default: begin
                note_time(it.client_time_ns);
                r.outcome = OUT_EMPTY;
            end
        endcase
        r.echo_slot = it.slot_index;
        r.slot_floor_now = in_rng ? slot_fl[s] : '0;
        r.floor_stalled = stalled_now;
        r.stall_run = run_len;
        r.peak_stall_run = run_peak;
        r.newest_client_time = t_max;
        return r;
    endfunction

    function automatic t_safl_in mk_in(input logic [1:0] req, input logic [7:0] slot,
                                       input logic [15:0] ep, input logic signed [63:0] fl,
                                       input logic [63:0] lo, input logic [63:0] hi,
                                       input logic signed [63:0] lt, input logic last,
                                       input logic signed [63:0] tns);
        t_safl_in it;
        it.req_type = req;
        it.slot_index = slot;
        it.epoch = ep;
        it.ack_floor = fl;
        it.recv_bits_low = lo;
        it.recv_bits_high = hi;
        it.latest_sent_tick = lt;
        it.last_of_message = last;
        it.client_time_ns = tns;
        return it;
    endfunction

    function automatic t_safl_out mk_out(input logic [3:0] oc, input logic [7:0] slot,
                                         input logic signed [63:0] fl, input logic stl,
                                         input logic [15:0] run, input logic [15:0] peak,
                                         input logic signed [63:0] tns);
        t_safl_out r;
        r.outcome = oc;
        r.echo_slot = slot;
        r.slot_floor_now = fl;
        r.floor_stalled = stl;
        r.stall_run = run;
        r.peak_stall_run = peak;
        r.newest_client_time = tns;
        return r;
    endfunction

    // first slot at or after a random start whose active bit matches
    function automatic int find_slot(input logic want_on);
        int s;
        s = $urandom_range(0, NSLOT - 1);
        for (int k = 0; k < NSLOT; k++) begin
            if (slot_on[s] == want_on) return s;
            s = (s + 1) % NSLOT;
        end
        return s;
    endfunction

    function automatic t_safl_in pick_random();
        t_safl_in           it;
        int                 s;
        int                 dice;
        int unsigned        u;
        logic signed [63:0] base;
        u = $urandom_range(0, 3000);
        it = mk_in(REQ_ACK, 0, 0, 0, {$urandom, $urandom}, {$urandom, $urandom},
                   S64_MAX, 1'b0, t_max + u - 1000);
        dice = $urandom_range(0, 99);
        if (dice < 8) begin
            // noise: every field free
            it.req_type = 2'($urandom);
            it.slot_index = 8'($urandom);
            it.epoch = 16'($urandom);
            it.ack_floor = {$urandom, $urandom};
            it.latest_sent_tick = {$urandom, $urandom};
            it.last_of_message = 1'($urandom);
            it.client_time_ns = {$urandom, $urandom};
        end else if (dice < 15) begin
            it.req_type = REQ_ACTIVATE;
            it.slot_index = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'(find_slot(1'b0));
        end else if (dice < 21) begin
            it.req_type = REQ_RELEASE;
            s = find_slot(1'b1);
            it.slot_index = 8'(s);
            it.epoch = ($urandom_range(0, 4) == 0) ? 16'($urandom) : slot_ep[s];
        end else if (dice < 25) begin
            it.req_type = REQ_EMPTY;
            it.slot_index = 8'($urandom);
        end else begin
            // well-formed message entry on an active slot
            s = find_slot(1'b1);
            if (msg_left == 0) msg_left = $urandom_range(1, 4);
            it.last_of_message = (msg_left == 1);
            msg_left--;
            it.slot_index = 8'(s);
            it.epoch = ($urandom_range(0, 15) == 0) ? 16'($urandom) : slot_ep[s];
            base = slot_fl[s];
            case ($urandom_range(0, 9))
                0, 1, 2: it.ack_floor = base;
                3, 4, 5: it.ack_floor = base + $urandom_range(1, 40);
                6, 7:    it.ack_floor = base - $urandom_range(1, 40);
                8:       it.ack_floor = {$urandom, $urandom};
                default: it.ack_floor = $urandom_range(0, 1) ? S64_MAX : S64_MIN;
            endcase
            case ($urandom_range(0, 3))
                0:       it.latest_sent_tick = base + $urandom_range(0, 30);
                1:       it.latest_sent_tick = {$urandom, $urandom};
                default: it.latest_sent_tick = S64_MAX;
            endcase
        end
        return it;
    endfunction

    task automatic add_row(input t_safl_in stim, input bit typed, input t_safl_out want);
        dir_stim[dir_n] = stim;
        dir_typed[dir_n] = typed;
        dir_want[dir_n] = want;
        dir_n++;
    endtask

    // offer one transaction, return in the step it was accepted
    task automatic offer(input t_safl_in it, input bit typed, input t_safl_out want);
        int        gap;
        t_safl_out predicted;
        gap = 0;
        if (idle_on) begin
            if (tx_calm != 0) begin
                tx_calm--;
            end else begin
                gap = $urandom_range(1, 13);
                tx_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                       : $urandom_range(0, 4);
            end
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        acc_cnt++;
        predicted = track_floor_step(it);
        exp_ring[exp_wr % EXP_DEPTH] = typed ? want : predicted;
        exp_wr++;
    endtask

    task automatic show_res(input string tag, input t_safl_out r);
        $display("  %s: outcome=%0d slot=%0d floor=%0d stalled=%0b run=%0d peak=%0d time=%0d",
                 tag, r.outcome, r.echo_slot, $signed(r.slot_floor_now), r.floor_stalled,
                 r.stall_run, r.peak_stall_run, $signed(r.newest_client_time));
    endtask

    task automatic log_mismatch(input string why, input t_safl_out want, input t_safl_out got);
        bad_cnt++;
        if (bad_cnt <= 10) begin
            $display("mismatch %0d at cycle %0d: %s", bad_cnt, cyc_cnt, why);
            show_res("expected", want);
            show_res("actual  ", got);
        end
    endtask

    // result checker
    t_safl_out chk_want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (o_out_data.outcome <= OUT_EMPTY) hist[o_out_data.outcome]++;
            if (exp_wr == exp_rd) begin
                log_mismatch("result with no transaction pending", blank, o_out_data);
            end else begin
                chk_want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_out_data.outcome !== chk_want.outcome ||
                    o_out_data.echo_slot !== chk_want.echo_slot ||
                    o_out_data.slot_floor_now !== chk_want.slot_floor_now ||
                    o_out_data.floor_stalled !== chk_want.floor_stalled ||
                    o_out_data.stall_run !== chk_want.stall_run ||
                    o_out_data.peak_stall_run !== chk_want.peak_stall_run ||
                    o_out_data.newest_client_time !== chk_want.newest_client_time) begin
                    log_mismatch("field mismatch", chk_want, o_out_data);
                end
            end
        end
    end

    // receiver: random stall bursts, calm stretches, one long hold-off
    always @(posedge i_clk) begin
        if (long_hold) begin
            i_out_stall <= 1'b1;
            rx_left <= 0;
        end else if (!idle_on) begin
            i_out_stall <= 1'b0;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            rx_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
        end else begin
            i_out_stall <= 1'b1;
            rx_left <= $urandom_range(0, 12);
        end
    end

    // hold the output side long enough for the pipeline to back up into the input
    initial begin
        wait (rnd_cnt >= 120);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYC_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cyc_cnt,
                     exp_wr - exp_rd);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        // after reset, activation edges, epoch mismatch, advance, merge, stale
        add_row(mk_in(REQ_ACK, 0, 0, 0, 0, 0, S64_MAX, 1, 5), 1,
                mk_out(OUT_SKIPPED, 0, 0, 0, 1, 1, 5));
        add_row(mk_in(REQ_ACTIVATE, 0, 0, 0, 0, 0, 0, 1, S64_MAX), 1,
                mk_out(OUT_ACTIVATED, 0, 0, 0, 1, 1, 5));
        add_row(mk_in(REQ_ACTIVATE, 255, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_out(OUT_SKIPPED, 255, 0, 0, 1, 1, 5));
        add_row(mk_in(REQ_ACTIVATE, 15, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_out(OUT_ACTIVATED, 15, 0, 0, 1, 1, 5));
        add_row(mk_in(REQ_ACTIVATE, 16, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_out(OUT_SKIPPED, 16, 0, 0, 1, 1, 5));
        add_row(mk_in(REQ_ACTIVATE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_out(OUT_SKIPPED, 0, 0, 0, 1, 1, 5));
        add_row(mk_in(REQ_ACK, 0, 16'hFFFF, 7, ONES64, ONES64, S64_MAX, 0, 0), 1,
                mk_out(OUT_EPOCH_MISMATCH, 0, 0, 0, 1, 1, 5));
        add_row(mk_in(REQ_ACK, 0, 1, 100, ONES64, 0, S64_MAX, 0, 0), 1,
                mk_out(OUT_ADVANCED, 0, 100, 0, 1, 1, 5));
        add_row(mk_in(REQ_ACK, 0, 1, 100, 0, ONES64, S64_MAX, 1, S64_MAX), 1,
                mk_out(OUT_MERGED, 0, 100, 0, 0, 1, S64_MAX));
        add_row(mk_in(REQ_ACK, 0, 1, 50, 0, 0, S64_MAX, 1, S64_MIN), 1,
                mk_out(OUT_STALE, 0, 100, 0, 1, 1, S64_MAX));
        // clamping, including a clamp below the stored floor
        add_row(mk_in(REQ_ACK, 0, 1, S64_MAX, 0, 0, 200, 0, 0), 0, blank);
        add_row(mk_in(REQ_ACK, 0, 1, 300, 1, 0, 150, 0, 0), 0, blank);
        // empty message inside an open one keeps its advance mark
        add_row(mk_in(REQ_EMPTY, 0, 0, 0, 0, 0, 0, 0, 9), 0, blank);
        add_row(mk_in(REQ_ACK, 0, 1, 150, 2, 0, S64_MAX, 1, 10), 0, blank);
        add_row(mk_in(REQ_ACK, 0, 1, 150, 0, 0, S64_MIN, 1, 11), 0, blank);
        // three messages with no advance raise the stalled flag
        add_row(mk_in(REQ_ACK, 0, 1, S64_MIN, ONES64, ONES64, S64_MIN, 1, -3), 0, blank);
        add_row(mk_in(REQ_ACK, 3, 1, 0, 0, 0, S64_MAX, 1, 12), 0, blank);
        add_row(mk_in(REQ_ACK, 200, 1, 0, 0, 0, S64_MAX, 1, 13), 0, blank);
        add_row(mk_in(REQ_RELEASE, 0, 5, 0, 0, 0, 0, 0, 0), 0, blank);
        add_row(mk_in(REQ_RELEASE, 255, 0, 0, 0, 0, 0, 0, 0), 0, blank);
        add_row(mk_in(REQ_RELEASE, 15, 1, 0, 0, 0, 0, 0, 0), 0, blank);
        add_row(mk_in(REQ_ACK, 15, 1, 0, 0, 0, S64_MAX, 1, 14), 0, blank);
        add_row(mk_in(REQ_ACK, 0, 1, S64_MAX, 0, 0, S64_MAX, 1, 15), 0, blank);
        add_row(mk_in(REQ_ACTIVATE, 15, 0, 0, 0, 0, 0, 0, 0), 0, blank);
        add_row(mk_in(REQ_RELEASE, 0, 1, 0, 0, 0, 0, 0, 0), 0, blank);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < dir_n; n++) offer(dir_stim[n], dir_typed[n], dir_want[n]);

        for (int n = 0; n < RND_ITEMS; n++) begin
            offer(pick_random(), 0, blank);
            rnd_cnt++;
        end

        // full-rate tail: activate, release and ack one slot back to back
        idle_on = 1'b0;
        for (int n = 0; n < SOAK_ROUNDS; n++) begin
            offer(mk_in(REQ_ACTIVATE, SOAK_SLOT, 0, 0, 0, 0, 0, 0, 0), 0, blank);
            offer(mk_in(REQ_RELEASE, SOAK_SLOT, slot_ep[SOAK_SLOT], 0, 0, 0, 0, 0, 0), 0, blank);
            offer(mk_in(REQ_ACK, SOAK_SLOT, slot_ep[SOAK_SLOT], 0, 0, 0, S64_MAX, 1, n), 0,
                  blank);
        end
        i_in_valid <= 1'b0;

        wait (exp_wr == exp_rd);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transactions: advanced %0d, merged %0d, stale %0d, epoch mismatch %0d",
                 acc_cnt, hist[OUT_ADVANCED], hist[OUT_MERGED], hist[OUT_STALE],
                 hist[OUT_EPOCH_MISMATCH]);
        $display("skipped %0d, activated %0d, released %0d, refused %0d, empty %0d, bad %0d",
                 hist[OUT_SKIPPED], hist[OUT_ACTIVATED], hist[OUT_RELEASED],
                 hist[OUT_REL_REFUSED], hist[OUT_EMPTY], bad_cnt);
        if (bad_cnt == 0 && exp_wr == exp_rd) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
